/* design/lmat_pkg.sv */
// shared types and constants for the light moving-average threshold block
`default_nettype none
package lmat_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int WINDOW_DEF    = 8;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;
    localparam int FQ_DEPTH      = 2;
    localparam int FQ_PTR_W      = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W      = $clog2(FQ_DEPTH + 1);
    localparam int DIV_STEPS     = SAMPLE_W;
    localparam int DIV_STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_W-1:0] THR_RESET = 12'd2048;

    // sample handed from the front queue to the back end
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } t_fq_head;

    typedef enum logic [1:0] {
        B_IDLE,
        B_UPDATE,
        B_DIV,
        B_DONE
    } t_back_state;

endpackage
`default_nettype wire

/* design/lmat_front.sv */
// input side: accepts samples and queues them for the back end
`default_nettype none
module lmat_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [lmat_pkg::SAMPLE_W-1:0]  i_sample,
    output lmat_pkg::t_fq_head             o_head,
    input  wire                            i_pop
);
    import lmat_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FQ_CNT_W-1:0] r_count, n_count;
    logic                w_push;
    logic                w_pop;

    assign s_axis_tready = (r_count != FQ_CNT_W'(FQ_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = i_pop && (r_count != '0);

    assign o_head.valid  = (r_count != '0);
    assign o_head.sample = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

endmodule
`default_nettype wire

/* design/lmat_back.sv */
// back end: sample ring, running sum, serial divider and result register
`default_nettype none
module lmat_back #(
    parameter int WINDOW = lmat_pkg::WINDOW_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  lmat_pkg::t_fq_head             i_head,
    output logic                           o_pop,
    input  wire  [lmat_pkg::SAMPLE_W-1:0]  i_threshold,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [lmat_pkg::SAMPLE_W-1:0]  o_average,
    output logic                           o_is_dark
);
    import lmat_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SAMPLE_W + CNT_W;

    t_back_state r_state, n_state;

    logic [SAMPLE_W-1:0]   r_ring [WINDOW];
    logic [SAMPLE_W-1:0]   r_old;
    logic [PTR_W-1:0]      r_wr_pos;
    logic [CNT_W-1:0]      r_fill;
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_div;
    logic [SAMPLE_W-1:0]   r_quo;
    logic [DIV_STEP_W-1:0] r_step;
    logic                  r_m_valid;
    logic [SAMPLE_W-1:0]   r_m_avg;
    logic                  r_m_dark;

    logic                  w_full;
    logic [SAMPLE_W-1:0]   w_old;
    logic [SUM_W-1:0]      w_sum;
    logic [CNT_W-1:0]      w_fill;
    logic [PTR_W-1:0]      w_pos_next;
    logic [CNT_W:0]        w_rem_shift;
    logic                  w_ge;
    logic [CNT_W:0]        w_rem_diff;
    logic                  w_last_step;
    logic                  w_out_free;

    logic                  c_update;
    logic                  c_div;
    logic                  c_load_out;

    // entries past the fill count were never written and count as zero
    assign w_full      = (r_fill == CNT_W'(WINDOW));
    assign w_old       = w_full ? r_old : '0;
    assign w_sum       = r_sum - SUM_W'(w_old) + SUM_W'(i_head.sample);
    assign w_fill      = w_full ? r_fill : r_fill + 1'b1;
    assign w_pos_next  = (r_wr_pos == PTR_W'(WINDOW - 1)) ? '0 : r_wr_pos + 1'b1;

    // restoring division, one quotient bit a cycle; the mean fits in 12 bits
    assign w_rem_shift = {r_rem, r_quo[SAMPLE_W-1]};
    assign w_ge        = (w_rem_shift >= {1'b0, r_div});
    assign w_rem_diff  = w_rem_shift - {1'b0, r_div};
    assign w_last_step = (r_step == DIV_STEP_W'(DIV_STEPS - 1));
    assign w_out_free  = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) n_state = B_UPDATE;
            end
            B_UPDATE: n_state = B_DIV;
            B_DIV: begin
                if (w_last_step) n_state = B_DONE;
            end
            B_DONE: begin
                if (w_out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        c_update   = 1'b0;
        c_div      = 1'b0;
        c_load_out = 1'b0;
        unique case (r_state)
            B_IDLE:   ;
            B_UPDATE: c_update   = 1'b1;
            B_DIV:    c_div      = 1'b1;
            B_DONE:   c_load_out = w_out_free;
            default:  ;
        endcase
    end

    assign o_pop = c_update;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_wr_pos  <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_update) begin
                r_wr_pos <= w_pos_next;
                r_fill   <= w_fill;
                r_sum    <= w_sum;
                r_step   <= '0;
            end else if (c_div) begin
                r_step <= r_step + 1'b1;
            end
            if (c_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_update) begin
            r_rem <= w_sum[SUM_W-1:SAMPLE_W];
            r_quo <= w_sum[SAMPLE_W-1:0];
            r_div <= w_fill;
        end else if (c_div) begin
            r_rem <= w_ge ? w_rem_diff[CNT_W-1:0] : w_rem_shift[CNT_W-1:0];
            r_quo <= {r_quo[SAMPLE_W-2:0], w_ge};
        end
        if (c_load_out) begin
            r_m_avg  <= r_quo;
            r_m_dark <= (r_quo >= i_threshold);
        end
    end

    // ring memory: one write, one registered read at the write position
    always_ff @(posedge i_clk) begin
        if (c_update) begin
            r_ring[r_wr_pos] <= i_head.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old <= r_ring[r_wr_pos];
    end

    assign m_axis_tvalid = r_m_valid;
    assign o_average     = r_m_avg;
    assign o_is_dark     = r_m_dark;

endmodule
`default_nettype wire

/* design/light_moving_average_threshold_top.sv */
// top level of the light moving-average filter with dark threshold
//
//  channel   dir   handshake                     payload
//  s_axis    in    s_axis_tvalid/s_axis_tready   tdata[11:0] sample
//  m_axis    out   m_axis_tvalid/m_axis_tready   tdata[11:0] average, [12] is_dark
//  cfg       in    i_cfg_we                      i_cfg_wdata dark threshold
//
// in the back end, each sample passes through an idle state that picks up the
// queue head, update, 12 divider steps and a result hand-off, with a
// bit-per-cycle divider that divides by the fill count.
// a two-entry queue takes samples while the back end works, and the result
// register lets the next sample start while a result waits to be taken.
// reset clears control state only; unfilled ring entries read as zero by way
// of the fill count, so there is no clearing pass.
`default_nettype none
module light_moving_average_threshold_top #(
    parameter int WINDOW = lmat_pkg::WINDOW_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [11:0] sample, [15:12] zero
    input  wire  [lmat_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [11:0] average, [12] is_dark, [15:13] zero
    output logic [lmat_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire                              i_cfg_we,
    input  wire  [lmat_pkg::SAMPLE_W-1:0]    i_cfg_wdata
);
    import lmat_pkg::*;

    logic [SAMPLE_W-1:0] r_dark_threshold;
    t_fq_head            w_head;
    logic                w_pop;
    logic [SAMPLE_W-1:0] w_average;
    logic                w_is_dark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_threshold <= THR_RESET;
        end else if (i_cfg_we) begin
            r_dark_threshold <= i_cfg_wdata;
        end
    end

    lmat_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sample      (s_axis_tdata[SAMPLE_W-1:0]),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    lmat_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_threshold   (r_dark_threshold),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_average     (w_average),
        .o_is_dark     (w_is_dark)
    );

    assign m_axis_tdata = {{(M_TDATA_W - SAMPLE_W - 1){1'b0}}, w_is_dark, w_average};

endmodule
`default_nettype wire

/* design/lmat_checker.sv */
// port-level checks for the light moving-average block, bound to the top level
`default_nettype none
module lmat_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [lmat_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input wire                              i_cfg_we,
    input wire [lmat_pkg::SAMPLE_W-1:0]     i_cfg_wdata
);
    import lmat_pkg::*;

    logic [2:0]          r_pending, n_pending;
    logic [SAMPLE_W-1:0] r_thr;
    logic                w_in_acc;
    logic                w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_pending = r_pending + {2'b00, w_in_acc} - {2'b00, w_out_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_thr     <= THR_RESET;
        end else begin
            r_pending <= n_pending;
            if (i_cfg_we) r_thr <= i_cfg_wdata;
        end
    end

    // results never outrun transactions taken in, and the block holds at most four
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != 3'd0))
        else $error("result shown with no transaction outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending <= 3'd4) && (!s_axis_tready -> (r_pending >= 3'd2)))
        else $error("outstanding count out of range or input stalled early");

    a_dark_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SAMPLE_W] == (m_axis_tdata[SAMPLE_W-1:0] >= r_thr)))
        else $error("dark flag disagrees with average and threshold");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind light_moving_average_threshold_top lmat_checker u_lmat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_wdata   (i_cfg_wdata)
);
`default_nettype wire

/* dv/light_moving_average_threshold_top_test.sv */
// testbench for the light moving-average threshold block: streamed samples checked against a window model
`timescale 1ns / 100ps
module light_moving_average_threshold_top_test;
    import lmat_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int WIN          = WINDOW_DEF;
    localparam int POS_W        = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int FILL_W       = $clog2(WIN + 1);
    localparam int SUM_W        = SAMPLE_W + $clog2(WIN + 1);
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 140;
    localparam int MAX_GAP      = 8;
    localparam int HOLD_AT      = 700;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 32;
    localparam int REPORT_LIMIT = 10;

    typedef enum {ITEM_SAMPLE, ITEM_SET_THRESHOLD, ITEM_PAUSE} feed_kind_t;
    typedef enum {DRV_FETCH, DRV_GAP, DRV_OFFER, DRV_DRAIN} drv_state_t;
    typedef enum {MIX_UNIFORM, MIX_EXTREMES, MIX_NEAR_THRESHOLD} mix_t;

    typedef struct {
        feed_kind_t          kind;
        logic [SAMPLE_W-1:0] value;
        int unsigned         gap;
    } feed_entry_t;

    typedef struct packed {
        logic                is_dark;
        logic [SAMPLE_W-1:0] average;
    } reading_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [11:0] sample, [15:12] zero
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [11:0] average, [12] is_dark, [15:13] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [SAMPLE_W-1:0]  i_cfg_wdata   = '0;

    light_moving_average_threshold_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    feed_entry_t sample_feed[$];
    reading_t    expected_readings[$];

    // window model
    logic [SAMPLE_W-1:0] win_ring [WIN];
    logic [POS_W-1:0]    win_pos;
    logic [FILL_W-1:0]   win_fill;
    logic [SUM_W-1:0]    win_sum;
    logic [SAMPLE_W-1:0] dark_level;

    drv_state_t  drv_st   = DRV_FETCH;
    feed_entry_t drv_cur;
    int unsigned drv_wait;
    int unsigned sent_cnt = 0;
    int unsigned recv_cnt = 0;
    int unsigned thr_writes = 0;
    int unsigned dark_seen = 0;
    int unsigned bright_seen = 0;
    int unsigned fail_cnt = 0;
    bit          sender_gappy = 1'b1;

    function automatic reading_t predict_mean_and_dark(input logic [SAMPLE_W-1:0] smp);
        reading_t         r;
        logic [SUM_W-1:0] quotient;
        win_sum = win_sum - win_ring[win_pos] + smp;
        win_ring[win_pos] = smp;
        win_pos = (win_pos == POS_W'(WIN - 1)) ? '0 : win_pos + 1'b1;
        if (win_fill < FILL_W'(WIN))
            win_fill = win_fill + 1'b1;
        quotient = win_sum / win_fill;
        r.average = (quotient > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : quotient[SAMPLE_W-1:0];
        r.is_dark = (r.average >= dark_level);
        return r;
    endfunction

    task automatic note_failure(input string what, input int want, input int got);
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT)
            $display("mismatch, %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic push_sample(input int value);
        feed_entry_t e;
        e.kind  = ITEM_SAMPLE;
        e.value = value[SAMPLE_W-1:0];
        e.gap   = sender_gappy ? $urandom_range(0, MAX_GAP) : 0;
        sample_feed.push_back(e);
    endtask

    task automatic push_threshold(input int value);
        feed_entry_t e;
        e.kind  = ITEM_SET_THRESHOLD;
        e.value = value[SAMPLE_W-1:0];
        e.gap   = 0;
        sample_feed.push_back(e);
    endtask

    task automatic push_pause();
        feed_entry_t e;
        e.kind  = ITEM_PAUSE;
        e.value = '0;
        e.gap   = 0;
        sample_feed.push_back(e);
    endtask

    // sender: one sample transaction at a time, register writes only once drained
    always @(posedge i_clk) begin : driver
        logic nxt_valid;
        logic nxt_we;
        nxt_valid = s_axis_tvalid;
        nxt_we    = 1'b0;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            drv_st    = DRV_FETCH;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent_cnt++;
                nxt_valid = 1'b0;
                drv_st    = DRV_FETCH;
            end
            if (drv_st == DRV_FETCH && sample_feed.size() != 0) begin
                drv_cur  = sample_feed.pop_front();
                drv_wait = drv_cur.gap;
                drv_st   = (drv_cur.kind == ITEM_SAMPLE) ? DRV_GAP : DRV_DRAIN;
            end
            case (drv_st)
                DRV_GAP: begin
                    if (drv_wait == 0) begin
                        nxt_valid = 1'b1;
                        s_axis_tdata <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, drv_cur.value};
                        drv_st = DRV_OFFER;
                    end else begin
                        drv_wait--;
                    end
                end
                DRV_DRAIN: begin
                    if (recv_cnt == sent_cnt) begin
                        if (drv_cur.kind == ITEM_SET_THRESHOLD) begin
                            nxt_we = 1'b1;
                            i_cfg_wdata <= drv_cur.value;
                            thr_writes++;
                        end
                        drv_st = DRV_FETCH;
                    end
                end
                default: ;
            endcase
        end
        s_axis_tvalid <= nxt_valid;
        i_cfg_we      <= nxt_we;
    end

    // receiver: random stalls per transaction, calm stretches, one long hold-off
    always @(posedge i_clk) begin : sink
        logic        nxt_ready;
        int unsigned stall;
        int unsigned hold_left;
        int unsigned taken;
        bit          sink_calm;
        nxt_ready = m_axis_tready;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
            stall     = 0;
            hold_left = 0;
            taken     = 0;
            sink_calm = 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            nxt_ready = (hold_left == 0);
        end else if (m_axis_tvalid && m_axis_tready) begin
            taken++;
            if (taken % 64 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT) begin
                hold_left = LONG_HOLD;
                stall     = 0;
                nxt_ready = 1'b0;
            end else begin
                stall     = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
                nxt_ready = (stall == 0);
            end
        end else if (!m_axis_tready) begin
            if (stall != 0)
                stall--;
            nxt_ready = (stall == 0);
        end
        m_axis_tready <= nxt_ready;
    end

    // prediction on accepted samples, comparison on accepted readings
    always @(posedge i_clk) begin : monitor
        reading_t want;
        int       k;
        if (!i_rst_n) begin
            for (k = 0; k < WIN; k++)
                win_ring[k] = '0;
            win_pos    = '0;
            win_fill   = '0;
            win_sum    = '0;
            dark_level = THR_RESET;
        end else begin
            if (i_cfg_we)
                dark_level = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(predict_mean_and_dark(s_axis_tdata[SAMPLE_W-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                recv_cnt <= recv_cnt + 1;
                if (m_axis_tdata[SAMPLE_W])
                    dark_seen++;
                else
                    bright_seen++;
                if (expected_readings.size() == 0) begin
                    note_failure("reading with no sample pending", 0, m_axis_tdata);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] != want.average)
                        note_failure("average", want.average, m_axis_tdata[SAMPLE_W-1:0]);
                    if (m_axis_tdata[SAMPLE_W] != want.is_dark)
                        note_failure("is_dark", want.is_dark, m_axis_tdata[SAMPLE_W]);
                    if (m_axis_tdata[M_TDATA_W-1:SAMPLE_W+1] != '0)
                        note_failure("tdata padding", 0, m_axis_tdata[M_TDATA_W-1:SAMPLE_W+1]);
                end
            end
        end
    end

    initial begin : stimulus
        int   ph;
        int   n;
        int   thr;
        int   smp;
        mix_t mix;

        // warm-up from reset at the default threshold, the ring wraps onto the first zero
        push_sample(0);
        push_sample(SAMPLE_MAX);
        for (n = 0; n < 7; n++)
            push_sample(SAMPLE_MAX);
        // full-scale threshold: dark only at a full-scale mean
        push_threshold(SAMPLE_MAX);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MAX - 1);
        // zero threshold: always dark
        push_threshold(0);
        push_sample(0);
        push_threshold(12'hAAA);
        push_sample(12'h555);
        push_sample(12'hAAA);
        push_sample(12'h800);
        push_sample(12'h7FF);
        push_pause();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       thr = 0;
                1:       thr = SAMPLE_MAX;
                2:       thr = 1;
                3:       thr = SAMPLE_MAX - 1;
                default: thr = $urandom_range(0, SAMPLE_MAX);
            endcase
            push_threshold(thr);
            sender_gappy = (ph % 4 != 3);
            mix = mix_t'($urandom_range(0, 2));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 39 && $urandom_range(0, 2) == 0)
                    push_pause();
                case (mix)
                    MIX_EXTREMES: begin
                        case ($urandom_range(0, 3))
                            0:       smp = 0;
                            1:       smp = SAMPLE_MAX;
                            default: smp = $urandom_range(0, SAMPLE_MAX);
                        endcase
                    end
                    // hover around the threshold so the flag keeps flipping
                    MIX_NEAR_THRESHOLD: begin
                        smp = thr + $urandom_range(0, 80) - 40;
                        if (smp < 0)
                            smp = 0;
                        if (smp > SAMPLE_MAX)
                            smp = SAMPLE_MAX;
                    end
                    default: smp = $urandom_range(0, SAMPLE_MAX);
                endcase
                push_sample(smp);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(sample_feed.size() == 0 && drv_st == DRV_FETCH && !s_axis_tvalid
                 && recv_cnt == sent_cnt))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0)
            note_failure("readings still owed at the end", 0, expected_readings.size());
        $display("run covered %0d samples under %0d threshold writes, warm-up and extremes",
                 sent_cnt, thr_writes);
        $display("readings: %0d dark, %0d bright; failures counted: %0d",
                 dark_seen, bright_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("timeout with %0d samples sent and %0d readings taken", sent_cnt, recv_cnt);
        $display("Verification failed");
        $finish;
    end

endmodule
